// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define TCP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tcp assertion failed");
// Same-cycle implication checked outside reset.
`define TCP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcp implication failed");
`else
`define TCP_ASSERT(label, clk, rst, prop)
`define TCP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/tcp_pkg.sv =====
// Shared types, codes and helper functions of the three-circle position solver.
`timescale 1ns / 1ps
`default_nettype none

package tcp_pkg;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_TOLERANCE    = 3'd0;
  localparam logic [2:0] REG_RADIUS_STEP  = 3'd1;
  localparam logic [2:0] REG_CONTAIN_STEP = 3'd2;
  localparam logic [2:0] REG_MAX_REFINE   = 3'd3;
  localparam logic [2:0] REG_MAX_CONTAIN  = 3'd4;

  localparam logic [11:0] REFINE_RESET        = 12'd1000;
  localparam logic [9:0]  CONTAIN_LIMIT_RESET = 10'd100;

  // Shared unit operations
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  // Working radius limits
  localparam logic signed [31:0] RLIM     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] RLIM_NEG = 32'sh8000_0001;
  localparam logic signed [32:0] RLIM_W     = 33'sh0_7FFF_FFFF;
  localparam logic signed [32:0] RLIM_NEG_W = 33'sh1_8000_0001;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } alu_rsp_t;

  typedef struct packed {
    logic [30:0] tolerance;
    logic [30:0] radius_step;
    logic [30:0] contain_step;
    logic [11:0] max_refine;
    logic [9:0]  max_contain;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [30:0]        ar;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic [30:0]        br;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        cr;
  } anchors_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               converged;
    logic [12:0]        steps;
  } result_t;

  // Saturate a 33-bit radius to +-(2^31 - 1)
  function automatic logic signed [31:0] sat_r(input logic signed [32:0] v);
    if (v > RLIM_W) return RLIM;
    if (v < RLIM_NEG_W) return RLIM_NEG;
    return v[31:0];
  endfunction

  // Move a radius by a step, up or down, saturating
  function automatic logic signed [31:0] step_r(input logic signed [31:0] r,
                                                input logic [30:0] step,
                                                input logic sub);
    logic signed [32:0] re;
    logic signed [32:0] se;
    re = {r[31], r};
    se = {2'b00, step};
    return sat_r(sub ? (re - se) : (re + se));
  endfunction

  // Saturate a 64-bit coordinate to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Magnitude of a 64-bit two's complement value
  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tcp_alu.sv =====
// Shared iterative unit: 64-bit multiply (low half), divide and integer square root.
`timescale 1ns / 1ps
`default_nettype none

module tcp_alu import tcp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [1:0]  op;
  logic [5:0]  cnt;
  logic [63:0] acc;
  logic [63:0] m;
  logic [63:0] q;
  logic [63:0] res;

  logic [63:0] acc_next;
  logic [63:0] m_next;
  logic [63:0] q_next;
  logic [63:0] fin;
  logic        last;
  logic [64:0] sh;
  logic [64:0] sub_div;
  logic        ge_div;
  logic [64:0] trial;
  logic        ge_sq;

  // One step of the selected operation
  always_comb begin
    sh      = {acc, q[63]};
    ge_div  = sh >= {1'b0, m};
    sub_div = sh - {1'b0, m};
    trial   = {1'b0, q} + {1'b0, m};
    ge_sq   = {1'b0, acc} >= trial;
    acc_next = acc;
    m_next   = m;
    q_next   = q;
    fin      = acc;
    last     = 1'b1;
    case (op)
      OP_MUL: begin
        acc_next = q[0] ? (acc + m) : acc;
        m_next   = m << 1;
        q_next   = q >> 1;
        fin      = acc_next;
        last     = (cnt == 6'd63);
      end
      OP_DIV: begin
        acc_next = ge_div ? sub_div[63:0] : sh[63:0];
        q_next   = {q[62:0], ge_div};
        fin      = q_next;
        last     = (cnt == 6'd63);
      end
      OP_SQRT: begin
        acc_next = ge_sq ? (acc - trial[63:0]) : acc;
        q_next   = ge_sq ? ((q >> 1) + m) : (q >> 1);
        m_next   = m >> 2;
        fin      = q_next;
        last     = (cnt == 6'd31);
      end
      default: begin
        fin  = acc;
        last = 1'b1;
      end
    endcase
  end

  // Control: busy flag and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      op  <= req.op;
      cnt <= '0;
      case (req.op)
        OP_MUL: begin
          acc <= '0;
          m   <= req.a;
          q   <= req.b;
        end
        OP_DIV: begin
          acc <= '0;
          m   <= req.b;
          q   <= req.a;
        end
        OP_SQRT: begin
          acc <= req.a;
          m   <= 64'h4000_0000_0000_0000;
          q   <= '0;
        end
        default: begin
          acc <= '0;
          m   <= '0;
          q   <= '0;
        end
      endcase
    end else if (busy) begin
      acc <= acc_next;
      m   <= m_next;
      q   <= q_next;
      cnt <= cnt + 6'd1;
      if (last) begin
        res <= fin;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.res  = res;

endmodule

`default_nettype wire

// ===== rtl/core/tcp_ctrl.sv =====
// Sequencer and working registers of the solver; drives the shared unit.
`timescale 1ns / 1ps
`default_nettype none

module tcp_ctrl import tcp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     start,
  input  anchors_t anc,
  output logic     idle,
  output logic     res_valid,
  output result_t  result,
  input  logic     res_take,
  output alu_req_t alu_req,
  input  alu_rsp_t alu_rsp
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_P_XX   = 5'd1;
  localparam logic [4:0] S_P_YY   = 5'd2;
  localparam logic [4:0] S_P_ROOT = 5'd3;
  localparam logic [4:0] S_P_HALF = 5'd4;
  localparam logic [4:0] S_CHK    = 5'd5;
  localparam logic [4:0] S_CONT   = 5'd6;
  localparam logic [4:0] S_R0SQ   = 5'd7;
  localparam logic [4:0] S_R1SQ   = 5'd8;
  localparam logic [4:0] S_TDIV   = 5'd9;
  localparam logic [4:0] S_AX_M   = 5'd10;
  localparam logic [4:0] S_AX_D   = 5'd11;
  localparam logic [4:0] S_AY_M   = 5'd12;
  localparam logic [4:0] S_AY_D   = 5'd13;
  localparam logic [4:0] S_ASQ    = 5'd14;
  localparam logic [4:0] S_H      = 5'd15;
  localparam logic [4:0] S_HX_M   = 5'd16;
  localparam logic [4:0] S_HX_D   = 5'd17;
  localparam logic [4:0] S_HY_M   = 5'd18;
  localparam logic [4:0] S_HY_D   = 5'd19;
  localparam logic [4:0] S_E_XX   = 5'd20;
  localparam logic [4:0] S_E_YY   = 5'd21;
  localparam logic [4:0] S_E_ROOT = 5'd22;
  localparam logic [4:0] S_PICK   = 5'd23;
  localparam logic [4:0] S_FIN    = 5'd24;
  localparam logic [4:0] S_DONE   = 5'd25;

  logic [4:0]         state;
  logic               issued;
  logic signed [31:0] cx0, cy0, cx1, cy1, cx2, cy2;
  logic signed [31:0] r0, r1, r2;
  logic [63:0]        dsq, hd, r0sq, r1sq, mtmp, aa, sumsq;
  logic [31:0]        d, h;
  logic [63:0]        a_val, p2x, p2y, rx, ry, px, py;
  logic [10:0]        cnt_c;
  logic [32:0]        e1, e2, cur_e, last_e;
  logic               dir, ok, conv, pt;
  logic [12:0]        steps;

  logic signed [32:0] dx_w, dy_w;
  logic               dx_neg, dy_neg;
  logic [31:0]        dx_mag, dy_mag;
  logic [63:0]        two_d, d_ext;
  logic [63:0]        t_w, t_mag;
  logic               t_neg;
  logic               a_neg;
  logic [63:0]        a_mag;
  logic [31:0]        r0_mag, r1_mag;
  logic signed [32:0] sum_r, diff_r;
  logic [32:0]        absdiff;
  logic               d_gt_sum, d_ge_diff;
  logic [63:0]        p1x, p1y, q2x, q2y, ptx, pty;
  logic [63:0]        ex, ey, ex_mag, ey_mag;
  logic               big;
  logic [64:0]        sq_sum;
  logic signed [33:0] ediff;
  logic [32:0]        e_w;
  logic               pick1;
  logic [32:0]        e_sel;
  logic [32:0]        tol_w;
  logic               dir_n;
  logic [12:0]        steps_n;
  logic               h_skip;
  logic [10:0]        cnt_n;

  // Derived values of the working registers
  always_comb begin
    dx_w    = {cx1[31], cx1} - {cx0[31], cx0};
    dy_w    = {cy1[31], cy1} - {cy0[31], cy0};
    dx_neg  = dx_w[32];
    dy_neg  = dy_w[32];
    dx_mag  = dx_neg ? 32'(33'd0 - dx_w) : dx_w[31:0];
    dy_mag  = dy_neg ? 32'(33'd0 - dy_w) : dy_w[31:0];
    two_d   = {31'd0, d, 1'b0};
    d_ext   = {32'd0, d};
    t_w     = r0sq - r1sq;
    t_neg   = t_w[63];
    t_mag   = mag64(t_w);
    a_neg   = a_val[63];
    a_mag   = mag64(a_val);
    r0_mag  = r0[31] ? (32'd0 - r0) : r0;
    r1_mag  = r1[31] ? (32'd0 - r1) : r1;
    sum_r   = {r0[31], r0} + {r1[31], r1};
    diff_r  = {r0[31], r0} - {r1[31], r1};
    absdiff = diff_r[32] ? (33'd0 - diff_r) : diff_r;
    d_gt_sum  = $signed({2'b00, d}) > $signed({sum_r[32], sum_r});
    d_ge_diff = {1'b0, d} >= absdiff;
    p1x     = p2x + rx;
    p1y     = p2y + ry;
    q2x     = p2x - rx;
    q2y     = p2y - ry;
    ptx     = pt ? q2x : p1x;
    pty     = pt ? q2y : p1y;
    ex      = ptx - {{32{cx2[31]}}, cx2};
    ey      = pty - {{32{cy2[31]}}, cy2};
    ex_mag  = mag64(ex);
    ey_mag  = mag64(ey);
    big     = (|ex_mag[63:32]) || (|ey_mag[63:32]);
    sq_sum  = {1'b0, aa} + {1'b0, alu_rsp.res};
    ediff   = $signed({2'b00, alu_rsp.res[31:0]}) - $signed({{2{r2[31]}}, r2});
    e_w     = ediff[33] ? 33'(34'd0 - ediff) : ediff[32:0];
    pick1   = e1 < e2;
    e_sel   = pick1 ? e1 : e2;
    tol_w   = {2'b00, cfg.tolerance};
    dir_n   = dir ^ (last_e < cur_e);
    steps_n = steps + 13'd1;
    h_skip  = mtmp >= r0sq;
    cnt_n   = cnt_c + 11'd1;
  end

  // Request to the shared unit
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = OP_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;
    case (state)
      S_P_XX: begin
        alu_req.start = !issued;
        alu_req.a     = {32'd0, dx_mag};
        alu_req.b     = {32'd0, dx_mag};
      end
      S_P_YY: begin
        alu_req.start = !issued;
        alu_req.a     = {32'd0, dy_mag};
        alu_req.b     = {32'd0, dy_mag};
      end
      S_P_ROOT: begin
        alu_req.start = !issued;
        alu_req.op    = OP_SQRT;
        alu_req.a     = dsq;
      end
      S_P_HALF: begin
        alu_req.start = !issued;
        alu_req.op    = OP_DIV;
        alu_req.a     = dsq;
        alu_req.b     = two_d;
      end
      S_R0SQ: begin
        alu_req.start = !issued;
        alu_req.a     = {32'd0, r0_mag};
        alu_req.b     = {32'd0, r0_mag};
      end
      S_R1SQ: begin
        alu_req.start = !issued;
        alu_req.a     = {32'd0, r1_mag};
        alu_req.b     = {32'd0, r1_mag};
      end
      S_TDIV: begin
        alu_req.start = !issued;
        alu_req.op    = OP_DIV;
        alu_req.a     = t_mag;
        alu_req.b     = two_d;
      end
      S_AX_M: begin
        alu_req.start = !issued;
        alu_req.a     = {32'd0, dx_mag};
        alu_req.b     = a_mag;
      end
      S_AY_M: begin
        alu_req.start = !issued;
        alu_req.a     = {32'd0, dy_mag};
        alu_req.b     = a_mag;
      end
      S_AX_D, S_AY_D, S_HX_D, S_HY_D: begin
        alu_req.start = !issued;
        alu_req.op    = OP_DIV;
        alu_req.a     = mtmp;
        alu_req.b     = d_ext;
      end
      S_ASQ: begin
        alu_req.start = !issued;
        alu_req.a     = a_mag;
        alu_req.b     = a_mag;
      end
      S_H: begin
        alu_req.start = !issued && !h_skip;
        alu_req.op    = OP_SQRT;
        alu_req.a     = r0sq - mtmp;
      end
      S_HX_M: begin
        alu_req.start = !issued;
        alu_req.a     = {32'd0, dy_mag};
        alu_req.b     = {32'd0, h};
      end
      S_HY_M: begin
        alu_req.start = !issued;
        alu_req.a     = {32'd0, dx_mag};
        alu_req.b     = {32'd0, h};
      end
      S_E_XX: begin
        alu_req.start = !issued && !big;
        alu_req.a     = ex_mag;
        alu_req.b     = ex_mag;
      end
      S_E_YY: begin
        alu_req.start = !issued;
        alu_req.a     = ey_mag;
        alu_req.b     = ey_mag;
      end
      S_E_ROOT: begin
        alu_req.start = !issued;
        alu_req.op    = OP_SQRT;
        alu_req.a     = sumsq;
      end
      default: begin
        alu_req.start = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          issued <= 1'b0;
          if (start) begin
            cx0    <= anc.ax;
            cy0    <= anc.ay;
            r0     <= {1'b0, anc.ar};
            cx1    <= anc.bx;
            cy1    <= anc.by;
            r1     <= {1'b0, anc.br};
            cx2    <= anc.cx;
            cy2    <= anc.cy;
            r2     <= {1'b0, anc.cr};
            cur_e  <= {2'b00, cfg.tolerance};
            last_e <= {2'b00, cfg.tolerance};
            dir    <= 1'b0;
            steps  <= '0;
            px     <= '0;
            py     <= '0;
            state  <= S_P_XX;
          end
        end
        // Center distance, computed once per item
        S_P_XX: begin
          if (!issued) issued <= 1'b1;
          else if (alu_rsp.done) begin
            issued <= 1'b0;
            aa     <= alu_rsp.res;
            state  <= S_P_YY;
          end
        end
        S_P_YY: begin
          if (!issued) issued <= 1'b1;
          else if (alu_rsp.done) begin
            issued <= 1'b0;
            dsq    <= sq_sum[64] ? '1 : sq_sum[63:0];
            state  <= S_P_ROOT;
          end
        end
        S_P_ROOT: begin
          if (!issued) issued <= 1'b1;
          else if (alu_rsp.done) begin
            issued <= 1'b0;
            d      <= alu_rsp.res[31:0];
            state  <= S_P_HALF;
          end
        end
        S_P_HALF: begin
          if (!issued) issued <= 1'b1;
          else if (alu_rsp.done) begin
            issued <= 1'b0;
            hd     <= alu_rsp.res;
            state  <= S_CHK;
          end
        end
        // Separate or coincident circles fail the attempt
        S_CHK: begin
          cnt_c <= '0;
          if ((d == 32'd0) || d_gt_sum) begin
            ok    <= 1'b0;
            state <= S_FIN;
          end else begin
            state <= S_CONT;
          end
        end
        // Containment fix: one step per cycle
        S_CONT: begin
          if (d_ge_diff) begin
            state <= S_R0SQ;
          end else begin
            if (r0 < r1) begin
              r0 <= step_r(r0, cfg.contain_step, 1'b0);
              r1 <= step_r(r1, cfg.contain_step, 1'b1);
            end else begin
              r1 <= step_r(r1, cfg.contain_step, 1'b0);
              r0 <= step_r(r0, cfg.contain_step, 1'b1);
            end
            cnt_c <= cnt_n;
            if (cnt_n > {1'b0, cfg.max_contain}) begin
              ok    <= 1'b0;
              state <= S_FIN;
            end
          end
        end
        S_R0SQ: begin
          if (!issued) issued <= 1'b1;
          else if (alu_rsp.done) begin
            issued <= 1'b0;
            r0sq   <= alu_rsp.res;
            state  <= S_R1SQ;
          end
        end
        S_R1SQ: begin
          if (!issued) issued <= 1'b1;
          else if (alu_rsp.done) begin
            issued <= 1'b0;
            r1sq   <= alu_rsp.res;
            state  <= S_TDIV;
          end
        end
        // a = trunc(t / 2d) + floor(dsq / 2d)
        S_TDIV: begin
          if (!issued) issued <= 1'b1;
          else if (alu_rsp.done) begin
            issued <= 1'b0;
            a_val  <= t_neg ? (hd - alu_rsp.res) : (hd + alu_rsp.res);
            state  <= S_AX_M;
          end
        end
        S_AX_M: begin
          if (!issued) issued <= 1'b1;
          else if (alu_rsp.done) begin
            issued <= 1'b0;
            mtmp   <= alu_rsp.res;
            state  <= S_AX_D;
          end
        end
        S_AX_D: begin
          if (!issued) issued <= 1'b1;
          else if (alu_rsp.done) begin
            issued <= 1'b0;
            p2x    <= {{32{cx0[31]}}, cx0} +
                      ((dx_neg ^ a_neg) ? (64'd0 - alu_rsp.res) : alu_rsp.res);
            state  <= S_AY_M;
          end
        end
        S_AY_M: begin
          if (!issued) issued <= 1'b1;
          else if (alu_rsp.done) begin
            issued <= 1'b0;
            mtmp   <= alu_rsp.res;
            state  <= S_AY_D;
          end
        end
        S_AY_D: begin
          if (!issued) issued <= 1'b1;
          else if (alu_rsp.done) begin
            issued <= 1'b0;
            p2y    <= {{32{cy0[31]}}, cy0} +
                      ((dy_neg ^ a_neg) ? (64'd0 - alu_rsp.res) : alu_rsp.res);
            state  <= S_ASQ;
          end
        end
        S_ASQ: begin
          if (!issued) issued <= 1'b1;
          else if (alu_rsp.done) begin
            issued <= 1'b0;
            mtmp   <= alu_rsp.res;
            state  <= S_H;
          end
        end
        // h clamps to zero when a^2 reaches rA^2
        S_H: begin
          if (!issued) begin
            if (h_skip) begin
              h     <= '0;
              state <= S_HX_M;
            end else begin
              issued <= 1'b1;
            end
          end else if (alu_rsp.done) begin
            issued <= 1'b0;
            h      <= alu_rsp.res[31:0];
            state  <= S_HX_M;
          end
        end
        S_HX_M: begin
          if (!issued) issued <= 1'b1;
          else if (alu_rsp.done) begin
            issued <= 1'b0;
            mtmp   <= alu_rsp.res;
            state  <= S_HX_D;
          end
        end
        S_HX_D: begin
          if (!issued) issued <= 1'b1;
          else if (alu_rsp.done) begin
            issued <= 1'b0;
            rx     <= dy_neg ? alu_rsp.res : (64'd0 - alu_rsp.res);
            state  <= S_HY_M;
          end
        end
        S_HY_M: begin
          if (!issued) issued <= 1'b1;
          else if (alu_rsp.done) begin
            issued <= 1'b0;
            mtmp   <= alu_rsp.res;
            state  <= S_HY_D;
          end
        end
        S_HY_D: begin
          if (!issued) issued <= 1'b1;
          else if (alu_rsp.done) begin
            issued <= 1'b0;
            ry     <= dx_neg ? (64'd0 - alu_rsp.res) : alu_rsp.res;
            pt     <= 1'b0;
            state  <= S_E_XX;
          end
        end
        // Distance of each candidate to circle C, saturating squares
        S_E_XX: begin
          if (!issued) begin
            if (big) begin
              sumsq <= '1;
              state <= S_E_ROOT;
            end else begin
              issued <= 1'b1;
            end
          end else if (alu_rsp.done) begin
            issued <= 1'b0;
            aa     <= alu_rsp.res;
            state  <= S_E_YY;
          end
        end
        S_E_YY: begin
          if (!issued) issued <= 1'b1;
          else if (alu_rsp.done) begin
            issued <= 1'b0;
            sumsq  <= sq_sum[64] ? '1 : sq_sum[63:0];
            state  <= S_E_ROOT;
          end
        end
        S_E_ROOT: begin
          if (!issued) issued <= 1'b1;
          else if (alu_rsp.done) begin
            issued <= 1'b0;
            if (!pt) begin
              e1    <= e_w;
              pt    <= 1'b1;
              state <= S_E_XX;
            end else begin
              e2    <= e_w;
              state <= S_PICK;
            end
          end
        end
        // Keep the nearer point, the second on a tie
        S_PICK: begin
          if (pick1) begin
            px <= p1x;
            py <= p1y;
          end else begin
            px <= q2x;
            py <= q2y;
          end
          if (e_sel > tol_w) begin
            cur_e <= e_sel;
            ok    <= 1'b0;
          end else begin
            ok    <= 1'b1;
          end
          state <= S_FIN;
        end
        // Direction, radius move, retry count
        S_FIN: begin
          dir    <= dir_n;
          last_e <= cur_e;
          r0     <= step_r(r0, cfg.radius_step, dir_n);
          r1     <= step_r(r1, cfg.radius_step, dir_n);
          r2     <= step_r(r2, cfg.radius_step, dir_n);
          steps  <= steps_n;
          if (steps_n > {1'b0, cfg.max_refine}) begin
            conv  <= 1'b0;
            state <= S_DONE;
          end else if (ok) begin
            conv  <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_CHK;
          end
        end
        S_DONE: begin
          if (res_take) state <= S_IDLE;
        end
        default: begin
          state  <= S_IDLE;
          issued <= 1'b0;
        end
      endcase
    end
  end

  assign idle             = (state == S_IDLE);
  assign res_valid        = (state == S_DONE);
  assign result.pos_x     = sat32(px);
  assign result.pos_y     = sat32(py);
  assign result.converged = conv;
  assign result.steps     = steps;

endmodule

`default_nettype wire

// ===== rtl/core/three_circle_position_solver.sv =====
// Top level of the three-circle position solver: config registers, sequencer, shared unit, output register.
//
// Channel  Signals                                    Direction
// -------  -----------------------------------------  ---------
// in       in_valid/in_ready, anchor_{a,b,c}_{x,y,r}  input
// out      out_valid/out_ready, pos_x/y, converged,   output
//          refine_steps
// cfg      cfg_we, cfg_addr, cfg_data                 input
//
// One item at a time. Setup is two squares, a root and a divide.
// Each attempt runs its multiplies, divides and roots on the shared multiply/divide/root unit
// and adds its containment steps; an item makes up to max_refine_steps + 1 attempts.
// Reset is synchronous; the output register holds a result while out_ready is low,
// and a finished item then waits in the sequencer until that register frees up.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module three_circle_position_solver import tcp_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] anchor_a_x,
  input  logic signed [31:0] anchor_a_y,
  input  logic [30:0]        anchor_a_r,
  input  logic signed [31:0] anchor_b_x,
  input  logic signed [31:0] anchor_b_y,
  input  logic [30:0]        anchor_b_r,
  input  logic signed [31:0] anchor_c_x,
  input  logic signed [31:0] anchor_c_y,
  input  logic [30:0]        anchor_c_r,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic               converged,
  output logic [12:0]        refine_steps,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [30:0]        cfg_data
);

  localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS;
  localparam logic [30:0] TOL_RESET     = 31'((ONE_FX + 64'd50) / 64'd100);
  localparam logic [30:0] STEP_RESET    = 31'((ONE_FX + 64'd50) / 64'd100);
  localparam logic [30:0] CONTAIN_RESET = 31'((ONE_FX + 64'd10) / 64'd20);

  cfg_t     cfg;
  anchors_t anc;
  result_t  result;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic     ctrl_idle;
  logic     res_valid;
  logic     res_take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tolerance    <= TOL_RESET;
      cfg.radius_step  <= STEP_RESET;
      cfg.contain_step <= CONTAIN_RESET;
      cfg.max_refine   <= REFINE_RESET;
      cfg.max_contain  <= CONTAIN_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TOLERANCE:    cfg.tolerance    <= cfg_data;
        REG_RADIUS_STEP:  cfg.radius_step  <= cfg_data;
        REG_CONTAIN_STEP: cfg.contain_step <= cfg_data;
        REG_MAX_REFINE:   cfg.max_refine   <= cfg_data[11:0];
        REG_MAX_CONTAIN:  cfg.max_contain  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign anc.ax = anchor_a_x;
  assign anc.ay = anchor_a_y;
  assign anc.ar = anchor_a_r;
  assign anc.bx = anchor_b_x;
  assign anc.by = anchor_b_y;
  assign anc.br = anchor_b_r;
  assign anc.cx = anchor_c_x;
  assign anc.cy = anchor_c_y;
  assign anc.cr = anchor_c_r;

  assign in_ready = ctrl_idle;

  tcp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (in_valid && in_ready),
    .anc       (anc),
    .idle      (ctrl_idle),
    .res_valid (res_valid),
    .result    (result),
    .res_take  (res_take),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp)
  );

  tcp_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Output register
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      pos_x        <= result.pos_x;
      pos_y        <= result.pos_y;
      converged    <= result.converged;
      refine_steps <= result.steps;
    end
  end

  // Checks
  `TCP_ASSERT(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready)
  `TCP_ASSERT(a_one_result, clk, rst, (res_valid && res_take) |=> !res_valid)
  `TCP_ASSERT_IMPLY(a_steps_nonzero, clk, rst, out_valid, refine_steps != 13'd0)

endmodule

`default_nettype wire
